[src/s2x_pkg.sv]
package s2x_pkg;

  localparam int PixW   = 24;
  localparam int CoordW = 8;
  localparam int DimW   = 9;
  localparam int MaxDim = 256;

  localparam logic [DimW-1:0] WidthRst  = 9'd160;
  localparam logic [DimW-1:0] HeightRst = 9'd144;

  // Blocks that one pixel can release, in output order.
  localparam int NumBlk  = 4;
  localparam int BlkNW   = 0;  // block (x-1, y-1)
  localparam int BlkN    = 1;  // block (x, y-1), row end only
  localparam int BlkW    = 2;  // block (x-1, y), last row only
  localparam int BlkSelf = 3;  // block (x, y), last pixel of the frame

  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [PixW-1:0] pixel_value;
    logic            frame_start;
  } pix_beat_t;

  typedef struct packed {
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic [PixW-1:0]   top_left;
    logic [PixW-1:0]   top_right;
    logic [PixW-1:0]   bottom_left;
    logic [PixW-1:0]   bottom_right;
    logic              last_of_run;
    logic              frame_done;
  } blk_beat_t;

  // One classified pixel with the column it brings into the window.
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [NumBlk-1:0] blocks;
    logic [PixW-1:0]   pix;
    logic [PixW-1:0]   up;
    logic [PixW-1:0]   mid;
  } item_t;

endpackage

[src/s2x_if.sv]
interface s2x_pix_if;
  logic                valid;
  logic                ready;
  s2x_pkg::pix_beat_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface s2x_blk_if;
  logic                valid;
  logic                ready;
  s2x_pkg::blk_beat_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/s2x_ram.sv]
module s2x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/s2x_fifo.sv]
module s2x_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d = count_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= DEPTH)
    else $error("queue count beyond depth");

endmodule

[src/s2x_front.sv]
module s2x_front #(
  parameter int LINE_DEPTH = 256,
  parameter int PIXEL_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  s2x_pix_if.sink                      pix_i,
  input  logic                         cfg_we_i,
  input  logic [s2x_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [s2x_pkg::DimW-1:0]     cfg_data_i,
  output logic                         item_valid_o,
  input  logic                         item_ready_i,
  output s2x_pkg::item_t               item_o
);

  import s2x_pkg::*;

  localparam int StoreBits  = (PIXEL_BITS < PixW) ? PIXEL_BITS : PixW;
  localparam int AddrW      = $clog2(LINE_DEPTH);
  localparam int WidthLimit = (LINE_DEPTH < MaxDim) ? LINE_DEPTH : MaxDim;
  localparam logic [DimW-1:0] WidthMax  = DimW'(WidthLimit);
  localparam logic [DimW-1:0] HeightMax = DimW'(MaxDim);

  logic [DimW-1:0]        width_q, height_q;
  logic [DimW-1:0]        eff_w, eff_h;
  logic [CoordW-1:0]      last_col, last_row_idx;
  logic [CoordW-1:0]      col_q, col_d, row_q, row_d;
  logic [CoordW-1:0]      x, y;
  logic                   row_end, last_row;
  logic [NumBlk-1:0]      blocks;
  logic                   accept, push;
  logic [AddrW-1:0]       rd_addr;

  logic                   s1_valid_q;
  logic [CoordW-1:0]      s1_x_q, s1_y_q;
  logic [NumBlk-1:0]      s1_blocks_q;
  logic [StoreBits-1:0]   s1_pix_q;
  logic [AddrW-1:0]       s1_addr_q;

  logic [2*StoreBits-1:0] ram_rdata, line_data, wr_data;
  logic [StoreBits-1:0]   up_pix, mid_pix;
  logic                   lw_valid_q;
  logic [AddrW-1:0]       lw_addr_q;
  logic [2*StoreBits-1:0] lw_data_q;

  always_comb begin
    priority if (width_q == '0) begin
      eff_w = DimW'(1);
    end else if (width_q > WidthMax) begin
      eff_w = WidthMax;
    end else begin
      eff_w = width_q;
    end
    priority if (height_q == '0) begin
      eff_h = DimW'(1);
    end else if (height_q > HeightMax) begin
      eff_h = HeightMax;
    end else begin
      eff_h = height_q;
    end
  end

  assign last_col     = CoordW'(eff_w - DimW'(1));
  assign last_row_idx = CoordW'(eff_h - DimW'(1));

  assign x        = pix_i.data.frame_start ? '0 : col_q;
  assign y        = pix_i.data.frame_start ? '0 : row_q;
  assign row_end  = (x >= last_col);
  assign last_row = (y >= last_row_idx);
  assign rd_addr  = AddrW'(x);

  always_comb begin
    blocks          = '0;
    blocks[BlkNW]   = (y != '0) && (x != '0);
    blocks[BlkN]    = (y != '0) && row_end;
    blocks[BlkW]    = last_row && (x != '0);
    blocks[BlkSelf] = last_row && row_end;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = last_row ? '0 : y + CoordW'(1);
      end else begin
        col_d = x + CoordW'(1);
        row_d = y;
      end
    end
  end

  assign push         = s1_valid_q && item_ready_i;
  assign pix_i.ready  = !s1_valid_q || item_ready_i;
  assign accept       = pix_i.valid && pix_i.ready;
  assign item_valid_o = s1_valid_q;

  // Both line rows of a column sit in one word: upper half is row y-2, lower is y-1.
  s2x_ram #(
    .WIDTH (2 * StoreBits),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // The previous pixel's write may land in the same cycle as this pixel's read
  // of the same column; the last written word is then the true contents.
  assign line_data = (lw_valid_q && (lw_addr_q == s1_addr_q)) ? lw_data_q : ram_rdata;
  assign up_pix    = line_data[2*StoreBits-1:StoreBits];
  assign mid_pix   = line_data[StoreBits-1:0];
  assign wr_data   = {mid_pix, s1_pix_q};

  always_comb begin
    item_o        = '0;
    item_o.x      = s1_x_q;
    item_o.y      = s1_y_q;
    item_o.blocks = s1_blocks_q;
    item_o.pix    = PixW'(s1_pix_q);
    item_o.up     = PixW'(up_pix);
    item_o.mid    = PixW'(mid_pix);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WidthRst;
      height_q   <= HeightRst;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      lw_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgFrameWidth:  width_q  <= cfg_data_i;
          CfgFrameHeight: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (push) begin
        s1_valid_q <= 1'b0;
      end
      if (push) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q      <= x;
      s1_y_q      <= y;
      s1_blocks_q <= blocks;
      s1_pix_q    <= pix_i.data.pixel_value[StoreBits-1:0];
      s1_addr_q   <= rd_addr;
    end
    if (push) begin
      lw_addr_q <= s1_addr_q;
      lw_data_q <= wr_data;
    end
  end

  a_col_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(col_q) < LINE_DEPTH)
    else $error("column counter outside the line buffer");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && row_end && last_row |=> (col_q == '0) && (row_q == '0))
    else $error("counters did not wrap after the last pixel of a frame");

endmodule

[src/s2x_back.sv]
module s2x_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  s2x_pkg::item_t  item_i,
  s2x_blk_if.source       blk_o
);

  import s2x_pkg::*;

  logic [PixW-1:0]   win_q [3][3];
  logic              cur_valid_q;
  logic [CoordW-1:0] cur_x_q, cur_y_q;
  logic [NumBlk-1:0] cur_blocks_q;
  logic [NumBlk-1:0] low, rest, blocks_next;
  logic              r2, c2;
  logic              can_issue, issue, pop, cur_free;
  logic [CoordW-1:0] bx, by;
  logic [PixW-1:0]   pe, pb, pd, pf, ph;
  logic [PixW-1:0]   pb_raw, pd_raw, pf_raw, ph_raw;
  logic              out_valid_q;
  blk_beat_t         blk_q, blk_d;

  // Lowest pending block goes out first.
  assign low  = cur_blocks_q & (~cur_blocks_q + NumBlk'(1));
  assign rest = cur_blocks_q & ~low;
  assign c2   = low[BlkN] | low[BlkSelf];
  assign r2   = low[BlkW] | low[BlkSelf];

  assign can_issue    = !out_valid_q || blk_o.ready;
  assign issue        = cur_valid_q && (cur_blocks_q != '0) && can_issue;
  assign blocks_next  = issue ? rest : cur_blocks_q;
  assign cur_free     = !cur_valid_q || (blocks_next == '0);
  assign item_ready_o = cur_free;
  assign pop          = item_valid_i && cur_free;

  assign bx = c2 ? cur_x_q : cur_x_q - CoordW'(1);
  assign by = r2 ? cur_y_q : cur_y_q - CoordW'(1);

  // Centre sits at window row 1 or 2 and column 1 or 2; neighbours outside
  // the frame clamp to the centre.
  always_comb begin
    pe     = r2 ? (c2 ? win_q[2][2] : win_q[2][1]) : (c2 ? win_q[1][2] : win_q[1][1]);
    pb_raw = r2 ? (c2 ? win_q[1][2] : win_q[1][1]) : (c2 ? win_q[0][2] : win_q[0][1]);
    pd_raw = r2 ? (c2 ? win_q[2][1] : win_q[2][0]) : (c2 ? win_q[1][1] : win_q[1][0]);
    pf_raw = r2 ? win_q[2][2] : win_q[1][2];
    ph_raw = c2 ? win_q[2][2] : win_q[2][1];
    pb     = (by != '0) ? pb_raw : pe;
    pd     = (bx != '0) ? pd_raw : pe;
    pf     = !c2 ? pf_raw : pe;
    ph     = !r2 ? ph_raw : pe;

    blk_d              = '0;
    blk_d.out_x        = bx;
    blk_d.out_y        = by;
    blk_d.top_left     = pe;
    blk_d.top_right    = pe;
    blk_d.bottom_left  = pe;
    blk_d.bottom_right = pe;
    if ((pb != ph) && (pd != pf)) begin
      blk_d.top_left     = (pd == pb) ? pd : pe;
      blk_d.top_right    = (pb == pf) ? pf : pe;
      blk_d.bottom_left  = (pd == ph) ? pd : pe;
      blk_d.bottom_right = (ph == pf) ? pf : pe;
    end
    blk_d.last_of_run = (rest == '0);
    blk_d.frame_done  = low[BlkSelf];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q  <= 1'b0;
      cur_blocks_q <= '0;
      out_valid_q  <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      if (pop) begin
        cur_valid_q  <= 1'b1;
        cur_blocks_q <= item_i.blocks;
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= item_i.up;
        win_q[1][2] <= item_i.mid;
        win_q[2][2] <= item_i.pix;
      end else begin
        cur_valid_q  <= cur_valid_q && (blocks_next != '0);
        cur_blocks_q <= blocks_next;
      end
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (blk_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_x_q <= item_i.x;
      cur_y_q <= item_i.y;
    end
    if (issue) begin
      blk_q <= blk_d;
    end
  end

  assign blk_o.valid = out_valid_q;
  assign blk_o.data  = blk_q;

  a_blocks_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && !pop |=> ((cur_blocks_q & ~$past(cur_blocks_q)) == '0))
    else $error("pending blocks grew without a new pixel");

  a_issue_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> out_valid_q)
    else $error("issued block not held in the output register");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && blk_q.frame_done |-> blk_q.last_of_run)
    else $error("frame end block is not the last of its pixel");

endmodule

[src/scale2x_pixel_upscaler_unit.sv]
// Path of a pixel: front register, queue, current-pixel register, output register.
// Throughput: one pixel per cycle while blk_o is ready; the back end emits one block per
// cycle; a pixel releasing two to four blocks (row ends, last row) holds up later pixels.
// The line buffer RAM is read at the beat, written as the pixel is queued, one port each.
// Reset clears counters, window, queue and valid flags and restores width 160 and
// height 144; line buffer contents are left as they are, with no clearing pass.
module scale2x_pixel_upscaler_unit #(
  parameter int LINE_DEPTH  = 256,
  parameter int PIXEL_BITS  = 24,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  s2x_pix_if.sink                      pix_i,
  s2x_blk_if.source                    blk_o,
  input  logic                         cfg_we_i,
  input  logic [s2x_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [s2x_pkg::DimW-1:0]     cfg_data_i
);

  import s2x_pkg::*;

  logic  front_valid, front_ready;
  item_t front_item;
  logic  queue_valid, queue_ready;
  item_t queue_item;

  s2x_front #(
    .LINE_DEPTH (LINE_DEPTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready),
    .item_o       (front_item)
  );

  s2x_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_item)
  );

  s2x_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_ready_o (queue_ready),
    .item_i       (queue_item),
    .blk_o        (blk_o)
  );

endmodule
